/* src/lcm3_pkg.sv */
`default_nettype none

package lcm3_pkg;

	localparam int OPERAND_WIDTH = 16;
	localparam int DVD_W         = 2 * OPERAND_WIDTH;
	localparam int RES_W         = 3 * OPERAND_WIDTH;
	localparam int GCD_K_W       = $clog2(OPERAND_WIDTH + 1);
	localparam int DIV_CNT_W     = $clog2(DVD_W + 1);

	typedef struct packed {
		logic [OPERAND_WIDTH-1:0] first_value;
		logic [OPERAND_WIDTH-1:0] second_value;
		logic [OPERAND_WIDTH-1:0] third_value;
	} in_item_t;

	typedef struct packed {
		logic [RES_W-1:0] lcm_value;
		logic             zero_error;
	} out_item_t;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_GCD1 = 9'b000000010,
		S_DIV1 = 9'b000000100,
		S_MUL1 = 9'b000001000,
		S_DIV2 = 9'b000010000,
		S_GCD2 = 9'b000100000,
		S_DIV3 = 9'b001000000,
		S_MUL2 = 9'b010000000,
		S_DONE = 9'b100000000
	} ctrl_state_t;

	// GCD operand pairs
	typedef enum logic {
		GS_AB = 1'b0,   // gcd(a, b)
		GS_CR = 1'b1    // gcd(c, l1 mod c)
	} gcd_sel_t;

	// divider operand pairs
	typedef enum logic [1:0] {
		DS_AG = 2'd0,   // a / gcd(a, b)
		DS_LC = 2'd1,   // l1 mod c
		DS_CG = 2'd2    // c / gcd(l1, c)
	} div_sel_t;

	typedef enum logic {
		MS_QB = 1'b0,   // l1 = (a / g1) * b
		MS_LQ = 1'b1    // lcm = l1 * (c / g2)
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     gcd_start;
		gcd_sel_t gcd_sel;
		logic     div_start;
		div_sel_t div_sel;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic in_zero;
		logic gcd_done;
		logic div_done;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

/* src/lcm3_gcd.sv */
`default_nettype none

module lcm3_gcd (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic [lcm3_pkg::OPERAND_WIDTH-1:0] u_in,
	input  wire logic [lcm3_pkg::OPERAND_WIDTH-1:0] v_in,
	output logic                                    done,
	output logic [lcm3_pkg::OPERAND_WIDTH-1:0]      gcd_out
);
	import lcm3_pkg::*;

	logic [OPERAND_WIDTH-1:0] u_q;
	logic [OPERAND_WIDTH-1:0] v_q;
	logic [GCD_K_W-1:0]       k_q;
	logic                     busy_q;
	logic                     finish;

	// binary GCD: one halving or one halved difference per cycle
	assign finish  = busy_q && ((u_q == '0) || (v_q == '0));
	assign done    = finish;
	assign gcd_out = (u_q | v_q) << k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (finish) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			u_q <= u_in;
			v_q <= v_in;
			k_q <= '0;
		end else if (busy_q && !finish) begin
			if (!u_q[0] && !v_q[0]) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (u_q >= v_q) begin
				u_q <= (u_q - v_q) >> 1;
			end else begin
				v_q <= (v_q - u_q) >> 1;
			end
		end
	end

endmodule

`default_nettype wire

/* src/lcm3_div.sv */
`default_nettype none

module lcm3_div (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic [lcm3_pkg::DVD_W-1:0]         dvd_in,
	input  wire logic [lcm3_pkg::OPERAND_WIDTH-1:0] dvs_in,
	output logic                                    done,
	output logic [lcm3_pkg::DVD_W-1:0]              quo,
	output logic [lcm3_pkg::OPERAND_WIDTH-1:0]      rem
);
	import lcm3_pkg::*;

	logic [DVD_W-1:0]         quo_q;
	logic [OPERAND_WIDTH-1:0] rem_q;
	logic [OPERAND_WIDTH-1:0] dvs_q;
	logic [DIV_CNT_W-1:0]     cnt_q;
	logic                     busy_q;
	logic [OPERAND_WIDTH:0]   trial;
	logic [OPERAND_WIDTH:0]   diff;
	logic                     ge;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};
	assign done  = busy_q && (cnt_q == '0);
	assign quo   = quo_q;
	assign rem   = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DVD_W);
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dvd_in;
			rem_q <= '0;
			dvs_q <= dvs_in;
		end else if (busy_q && (cnt_q != '0)) begin
			rem_q <= ge ? diff[OPERAND_WIDTH-1:0] : trial[OPERAND_WIDTH-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

endmodule

`default_nettype wire

/* src/lcm3_dp.sv */
`default_nettype none

module lcm3_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lcm3_pkg::in_item_t   in_item,
	input  wire lcm3_pkg::dp_cmd_t    cmd,
	output lcm3_pkg::dp_status_t      status,
	input  wire logic                 out_ready,
	output logic                      out_valid,
	output lcm3_pkg::out_item_t       out_item
);
	import lcm3_pkg::*;

	logic [OPERAND_WIDTH-1:0] a_q;
	logic [OPERAND_WIDTH-1:0] b_q;
	logic [OPERAND_WIDTH-1:0] c_q;
	logic                     err_q;
	logic [OPERAND_WIDTH-1:0] g_q;
	logic [DVD_W-1:0]         l1_q;
	logic [RES_W-1:0]         prod_q;
	out_item_t                out_q;
	logic                     out_valid_q;

	logic [OPERAND_WIDTH-1:0] gcd_u;
	logic [OPERAND_WIDTH-1:0] gcd_v;
	logic                     gcd_done;
	logic [OPERAND_WIDTH-1:0] gcd_res;
	logic [DVD_W-1:0]         div_dvd;
	logic [OPERAND_WIDTH-1:0] div_dvs;
	logic                     div_done;
	logic [DVD_W-1:0]         div_quo;
	logic [OPERAND_WIDTH-1:0] div_rem;
	logic [DVD_W-1:0]         mul_a;
	logic [OPERAND_WIDTH-1:0] mul_b;
	logic [RES_W-1:0]         mul_p;

	always_comb begin
		case (cmd.gcd_sel)
			GS_AB: begin
				gcd_u = a_q;
				gcd_v = b_q;
			end
			GS_CR: begin
				gcd_u = c_q;
				gcd_v = div_rem;
			end
			default: begin
				gcd_u = a_q;
				gcd_v = b_q;
			end
		endcase
	end

	always_comb begin
		case (cmd.div_sel)
			DS_AG: begin
				div_dvd = {{OPERAND_WIDTH{1'b0}}, a_q};
				div_dvs = g_q;
			end
			DS_LC: begin
				div_dvd = l1_q;
				div_dvs = c_q;
			end
			DS_CG: begin
				div_dvd = {{OPERAND_WIDTH{1'b0}}, c_q};
				div_dvs = g_q;
			end
			default: begin
				div_dvd = l1_q;
				div_dvs = c_q;
			end
		endcase
	end

	always_comb begin
		case (cmd.mul_sel)
			MS_QB: begin
				mul_a = {{OPERAND_WIDTH{1'b0}}, div_quo[OPERAND_WIDTH-1:0]};
				mul_b = b_q;
			end
			MS_LQ: begin
				mul_a = l1_q;
				mul_b = div_quo[OPERAND_WIDTH-1:0];
			end
			default: begin
				mul_a = l1_q;
				mul_b = b_q;
			end
		endcase
	end

	assign mul_p = {{OPERAND_WIDTH{1'b0}}, mul_a} * {{DVD_W{1'b0}}, mul_b};

	lcm3_gcd u_gcd (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.gcd_start),
		.u_in    (gcd_u),
		.v_in    (gcd_v),
		.done    (gcd_done),
		.gcd_out (gcd_res)
	);

	lcm3_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.dvd_in (div_dvd),
		.dvs_in (div_dvs),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	assign status.in_zero  = (in_item.first_value == '0) || (in_item.second_value == '0)
		|| (in_item.third_value == '0);
	assign status.gcd_done = gcd_done;
	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q   <= in_item.first_value;
			b_q   <= in_item.second_value;
			c_q   <= in_item.third_value;
			err_q <= status.in_zero;
		end
		if (gcd_done) begin
			g_q <= gcd_res;
		end
		if (cmd.mul_en) begin
			case (cmd.mul_sel)
				MS_QB: l1_q <= mul_p[DVD_W-1:0];
				MS_LQ: prod_q <= mul_p;
				default: prod_q <= mul_p;
			endcase
		end
		if (cmd.out_load) begin
			out_q.lcm_value  <= err_q ? '0 : prod_q;
			out_q.zero_error <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

/* src/lcm3_ctrl.sv */
`default_nettype none

module lcm3_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire lcm3_pkg::dp_status_t status,
	output lcm3_pkg::dp_cmd_t         cmd
);
	import lcm3_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        launch_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d       = state_q;
		cmd.load      = 1'b0;
		cmd.gcd_start = 1'b0;
		cmd.gcd_sel   = GS_AB;
		cmd.div_start = 1'b0;
		cmd.div_sel   = DS_AG;
		cmd.mul_en    = 1'b0;
		cmd.mul_sel   = MS_QB;
		cmd.out_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = status.in_zero ? S_DONE : S_GCD1;
				end
			end
			S_GCD1: begin
				cmd.gcd_start = launch_q;
				cmd.gcd_sel   = GS_AB;
				if (status.gcd_done) state_d = S_DIV1;
			end
			S_DIV1: begin
				cmd.div_start = launch_q;
				cmd.div_sel   = DS_AG;
				if (status.div_done) state_d = S_MUL1;
			end
			S_MUL1: begin
				cmd.div_sel = DS_AG;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_QB;
				state_d     = S_DIV2;
			end
			S_DIV2: begin
				cmd.div_start = launch_q;
				cmd.div_sel   = DS_LC;
				if (status.div_done) state_d = S_GCD2;
			end
			S_GCD2: begin
				cmd.gcd_start = launch_q;
				cmd.gcd_sel   = GS_CR;
				if (status.gcd_done) state_d = S_DIV3;
			end
			S_DIV3: begin
				cmd.div_start = launch_q;
				cmd.div_sel   = DS_CG;
				if (status.div_done) state_d = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_LQ;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// launch the unit of a state in its first cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			launch_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= (state_d != state_q);
		end
	end

endmodule

`default_nettype wire

/* src/lcm_of_three.sv */
`default_nettype none

// channel   | valid           | ready           | payload
// ----------+-----------------+-----------------+------------------------------------
// operands  | operands_valid  | operands_ready  | operands: first/second/third_value
// result    | result_valid    | result_ready    | result: lcm_value, zero_error
//
// One item is worked at a time. Each item takes three 32-step restoring divisions and
// two binary GCD runs on one shared divider and one GCD unit. An item with a zero
// operand skips the arithmetic and goes straight to the done state, where its result
// is loaded once the output register is free.
// Reset clears the controller and the result valid flag.
// A stalled result sits in the output register while the next item is worked.

module lcm_of_three (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                operands_valid,
	output logic                     operands_ready,
	input  wire lcm3_pkg::in_item_t  operands,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output lcm3_pkg::out_item_t      result
);
	import lcm3_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// sequence the steps: gcd(a,b), a/g1, l1 = (a/g1)*b, l1 mod c,
	// gcd(c, l1 mod c), c/g2, lcm = l1*(c/g2)
	lcm3_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (operands_valid),
		.in_ready (operands_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// hold operands, intermediate values and the result register
	lcm3_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (operands),
		.cmd       (cmd),
		.status    (status),
		.out_ready (result_ready),
		.out_valid (result_valid),
		.out_item  (result)
	);

	// an error result always carries a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.zero_error |-> result.lcm_value == '0)
		else $error("error result with nonzero value");

	// the two iterative units never start together
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.gcd_start && cmd.div_start))
		else $error("gcd and divider started in the same cycle");

	// an accepted item whose operands are all nonzero launches the first GCD right away
	a_gcd_launch: assert property (@(posedge clk) disable iff (!arst_n)
		operands_valid && operands_ready && !status.in_zero |=> cmd.gcd_start)
		else $error("first gcd not launched");

	// never overwrite a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> status.out_free)
		else $error("result register overwritten");

endmodule

`default_nettype wire
